// ===== rtl/core/srds_pkg.sv =====
// ----------------------------------------------------------------------------
// srds_pkg
// Shared constants, types and helper functions for the signed radix to digit
// string converter.
// ----------------------------------------------------------------------------
package srds_pkg;

    localparam int VALUE_W    = 64;                   // input field width
    localparam int VALUE_BITS = 64;                   // bits taken as the value
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int DEPTH      = VALUE_BITS;           // max digits per value
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'b1;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
    localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [DIGIT_W-1:0]    remainder;
    } div_result_t;

    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] e;
        if (r < RADIX_MIN)
            e = RADIX_MIN;
        else if (r > RADIX_MAX)
            e = RADIX_MAX;
        else
            e = r;
        return e;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (d < DIGIT_W'(10))
            c = ZERO_CHAR + dx;
        else if (upper)
            c = UPPER_A + dx - CHAR_W'(10);
        else
            c = LOWER_A + dx - CHAR_W'(10);
        return c;
    endfunction

endpackage

// ===== rtl/core/srds_divider.sv =====
// ----------------------------------------------------------------------------
// srds_divider
// Restoring divider, one quotient bit per cycle: magnitude by radix.
// ----------------------------------------------------------------------------
module srds_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [srds_pkg::VALUE_BITS-1:0]   dividend,
    input  logic [srds_pkg::RADIX_W-1:0]      divisor,
    output srds_pkg::div_result_t             result
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [srds_pkg::CNT_W-1:0]          cnt_reg;
    logic [srds_pkg::VALUE_BITS-1:0]     quo_reg;
    logic [srds_pkg::DIGIT_W-1:0]        rem_reg;
    logic [srds_pkg::RADIX_W-1:0]        div_reg;

    logic [srds_pkg::DIGIT_W:0]          trial;
    logic [srds_pkg::DIGIT_W:0]          diff;
    logic                                ge;

    assign trial = {rem_reg, quo_reg[srds_pkg::VALUE_BITS-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= srds_pkg::CNT_W'(srds_pkg::VALUE_BITS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[srds_pkg::VALUE_BITS-2:0], ge};
            rem_reg <= ge ? diff[srds_pkg::DIGIT_W-1:0] : trial[srds_pkg::DIGIT_W-1:0];
        end
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

// ===== rtl/core/srds_digit_store.sv =====
// ----------------------------------------------------------------------------
// srds_digit_store
// Digit memory: remainders written least significant first, read back in
// reverse. One write port, one registered read port.
// ----------------------------------------------------------------------------
module srds_digit_store
(
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [srds_pkg::IDX_W-1:0]      wr_addr,
    input  logic [srds_pkg::DIGIT_W-1:0]    wr_data,
    input  logic                            rd_en,
    input  logic [srds_pkg::IDX_W-1:0]      rd_addr,
    output logic [srds_pkg::DIGIT_W-1:0]    rd_data
);

    logic [srds_pkg::DIGIT_W-1:0] mem [srds_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/signed_radix_to_digit_string.sv =====
// ----------------------------------------------------------------------------
// signed_radix_to_digit_string
// Converts a signed integer to ASCII digits in a base from 2 to 36, most
// significant digit first, with a leading minus for negative base-10 values.
//
//   channel   direction  handshake           payload
//   s_*       in         s_tvalid/s_tready   s_tdata = value
//   m_*       out        m_tvalid/m_tready   m_tdata = character, m_tlast
//   cfg_*     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each digit comes from the shared restoring divider; each emitted digit is
// then read back through the digit store read port (ST_READ, then ST_SHOW).
// s_tready is low from accept until the last character is loaded for output.
// Reset restores radix 10 and upper case; a stalled m_tready holds the sign and digit output states.
// ----------------------------------------------------------------------------
module signed_radix_to_digit_string
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [srds_pkg::VALUE_W-1:0]     s_tdata,   // [63:0] value

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [srds_pkg::CHAR_W-1:0]      m_tdata,   // [7:0] character
    output logic                             m_tlast,   // last_char

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srds_pkg::RADIX_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_SHOW
    } state_t;

    state_t                               state_reg, state_next;
    logic [srds_pkg::RADIX_W-1:0]         radix_reg;
    logic                                 upper_reg;
    logic [srds_pkg::RADIX_W-1:0]         base_reg, base_next;
    logic                                 minus_reg, minus_next;
    logic [srds_pkg::IDX_W-1:0]           ptr_reg, ptr_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [srds_pkg::CHAR_W-1:0]          out_char_reg, out_char_next;
    logic                                 out_last_reg, out_last_next;

    logic [srds_pkg::VALUE_BITS-1:0]      raw;
    logic                                 negative;
    logic [srds_pkg::VALUE_BITS-1:0]      mag;
    logic [srds_pkg::RADIX_W-1:0]         base_eff;

    logic                                 div_start;
    logic [srds_pkg::VALUE_BITS-1:0]      div_dividend;
    srds_pkg::div_result_t                div_res;

    logic                                 wr_en;
    logic                                 rd_en;
    logic [srds_pkg::DIGIT_W-1:0]         rd_data;
    logic                                 out_free;
    logic                                 s_accept;

    assign raw      = s_tdata[srds_pkg::VALUE_BITS-1:0];
    assign negative = raw[srds_pkg::VALUE_BITS-1];
    assign mag      = negative ? (~raw + 1'b1) : raw;
    assign base_eff = srds_pkg::eff_radix(radix_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= srds_pkg::RADIX_RESET;
            upper_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                srds_pkg::REG_RADIX: radix_reg <= cfg_data;
                srds_pkg::REG_UPPER: upper_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    srds_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (state_reg == ST_IDLE ? base_eff : base_reg),
        .result   (div_res)
    );

    srds_digit_store u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (div_res.remainder),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        minus_next     = minus_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        div_start      = 1'b0;
        div_dividend   = mag;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    base_next  = base_eff;
                    minus_next = negative && (base_eff == srds_pkg::RADIX_DEC);
                    ptr_next   = '0;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_dividend = div_res.quotient;
                if (div_res.done)
                begin
                    wr_en = 1'b1;
                    if (div_res.quotient == '0)
                        state_next = minus_reg ? ST_SIGN : ST_READ;
                    else
                    begin
                        div_start = 1'b1;
                        ptr_next  = ptr_reg + 1'b1;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = srds_pkg::MINUS_CHAR;
                    out_last_next  = 1'b0;
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = srds_pkg::digit_char(rd_data, upper_reg);
                    out_last_next  = (ptr_reg == '0);
                    if (ptr_reg == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        ptr_next   = ptr_reg - 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        minus_reg    <= minus_next;
        ptr_reg      <= ptr_next;
    end

endmodule

// ===== dv/signed_radix_to_digit_string_tb.sv =====
// ----------------------------------------------------------------------------
// signed_radix_to_digit_string_tb
// Self-checking bench for the integer to ASCII digit converter. A directed
// table covers zero, both extremes, minus one, every radix clamp and both
// letter cases. Random phases follow, each with new register settings. Every
// character is checked against its row text or an in-bench digit predictor.
// Both streams idle at random; one long receiver hold backs up into the input.
// ----------------------------------------------------------------------------
module signed_radix_to_digit_string_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 5_000_000;
    localparam int LONG_HOLD    = 6000;
    localparam int DRAIN_CYCLES = 2 * (srds_pkg::VALUE_BITS + 1);
    localparam int RANDOM_ITEMS = 110;

    typedef struct packed {
        logic [srds_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } char_t;

    typedef enum logic { ROW_CFG, ROW_VALUE } row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        logic [srds_pkg::CFG_IDX_W-1:0]   idx;
        logic [srds_pkg::RADIX_W-1:0]     data;
        logic [srds_pkg::VALUE_W-1:0]     value;
        string                            text;
    } row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [srds_pkg::VALUE_W-1:0]    s_tdata;    // [63:0] value
    logic                            m_tvalid;
    logic                            m_tready;
    logic [srds_pkg::CHAR_W-1:0]     m_tdata;    // [7:0] character
    logic                            m_tlast;    // last_char
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [srds_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [srds_pkg::RADIX_W-1:0]    cfg_data;

    char_t                           char_q[$];
    row_t                            rows[$];
    logic [srds_pkg::RADIX_W-1:0]    radix_reg;
    logic                            upper_reg;
    bit                              hold_req;
    int                              n_errors;
    int                              n_values;
    int                              n_chars;
    int                              n_cfg;

    signed_radix_to_digit_string u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned eff_base();
        if (radix_reg < 2)
            return 2;
        if (radix_reg > 36)
            return 36;
        return 32'(radix_reg);
    endfunction

    function automatic void predict_digits(input logic [srds_pkg::VALUE_W-1:0] v);
        logic [srds_pkg::VALUE_BITS-1:0] raw;
        logic [srds_pkg::VALUE_BITS-1:0] mag;
        logic                            neg;
        int unsigned                     base;
        logic [srds_pkg::DIGIT_W-1:0]    rev[srds_pkg::VALUE_BITS];
        logic [srds_pkg::CHAR_W-1:0]     c;
        int                              nd;
        int                              i;
        raw  = v[srds_pkg::VALUE_BITS-1:0];
        neg  = raw[srds_pkg::VALUE_BITS-1];
        mag  = neg ? -raw : raw;
        base = eff_base();
        nd   = 0;
        do
        begin
            rev[nd] = srds_pkg::DIGIT_W'(mag % base);
            nd++;
            mag = mag / base;
        end
        while (mag != 0 && nd < srds_pkg::VALUE_BITS);
        if (neg && base == 10)
            char_q.push_back(char_t'{srds_pkg::MINUS_CHAR, 1'b0});
        for (i = nd - 1; i >= 0; i--)
        begin
            if (rev[i] < 10)
                c = srds_pkg::ZERO_CHAR + srds_pkg::CHAR_W'(rev[i]);
            else
                c = (upper_reg ? srds_pkg::UPPER_A : srds_pkg::LOWER_A)
                    + srds_pkg::CHAR_W'(rev[i]) - srds_pkg::CHAR_W'(10);
            char_q.push_back(char_t'{c, i == 0});
        end
    endfunction

    function automatic void push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            char_q.push_back(char_t'{srds_pkg::CHAR_W'(s[i]), i == s.len() - 1});
    endfunction

    function automatic logic [srds_pkg::VALUE_W-1:0] rand_value();
        logic [srds_pkg::VALUE_W-1:0] v;
        logic [srds_pkg::VALUE_W-1:0] p;
        int unsigned                  base;
        int                           k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = {$urandom, $urandom};
            4:          v = srds_pkg::VALUE_W'($urandom_range(0, 40));
            5:          v = -srds_pkg::VALUE_W'($urandom_range(1, 40));
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       v = '0;
                    1:       v = '1;
                    2:       v = {1'b1, {(srds_pkg::VALUE_W-1){1'b0}}};
                    default: v = {1'b0, {(srds_pkg::VALUE_W-1){1'b1}}};
                endcase
            end
            7:
            begin
                base = eff_base();
                p = srds_pkg::VALUE_W'(1);
                k = $urandom_range(1, 63);
                repeat (k)
                    if (p <= {1'b0, {(srds_pkg::VALUE_W-1){1'b1}}} / base)
                        p = p * base;
                v = p + srds_pkg::VALUE_W'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            8:          v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default:    v = -({$urandom, $urandom} >> $urandom_range(0, 63));
        endcase
        return v;
    endfunction

    task automatic add_cfg(input logic [srds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srds_pkg::RADIX_W-1:0] data);
        row_t r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        r.value = '0;
        r.text  = "";
        rows.push_back(r);
    endtask

    task automatic add_val(input logic [srds_pkg::VALUE_W-1:0] v, input string text);
        row_t r;
        r.kind  = ROW_VALUE;
        r.idx   = srds_pkg::REG_RADIX;
        r.data  = '0;
        r.value = v;
        r.text  = text;
        rows.push_back(r);
    endtask

    task automatic send_value(input logic [srds_pkg::VALUE_W-1:0] v, input string text,
                              input bit calm);
        int gap;
        gap = calm ? 0 : gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge clk); while (!s_tready);
        if (text.len() > 0)
            push_text(text);
        else
            predict_digits(v);
        n_values++;
    endtask

    task automatic cfg_write(input logic [srds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [srds_pkg::RADIX_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == srds_pkg::REG_RADIX)
            radix_reg = data;
        else
            upper_reg = data[0];
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (char_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receive side: random stalls, calm stretches, one long hold on request
    initial
    begin
        int    stall;
        int    calm_left;
        char_t e;
        stall     = 0;
        calm_left = 0;
        m_tready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = LONG_HOLD;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                n_chars++;
                if (char_q.size() == 0)
                begin
                    $error("unexpected character: got %h", m_tdata);
                    n_errors++;
                end
                else
                begin
                    e = char_q.pop_front();
                    if (m_tdata !== e.ch)
                    begin
                        $error("character mismatch: expected %h, got %h", e.ch, m_tdata);
                        n_errors++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("last_char mismatch: expected %b, got %b", e.last, m_tlast);
                        n_errors++;
                    end
                end
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 39) == 0)
                    calm_left = $urandom_range(20, 80);
                stall = (calm_left > 0) ? 0 : gap_len();
            end
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d characters outstanding",
                 LIMIT_CYCLES, char_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int n_directed;
        int rand_items;
        int phase;
        int len;
        bit calm;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = srds_pkg::REG_RADIX;
        cfg_data  = '0;
        hold_req  = 1'b0;
        radix_reg = srds_pkg::RADIX_RESET;
        upper_reg = 1'b1;
        n_errors  = 0;
        n_values  = 0;
        n_chars   = 0;
        n_cfg     = 0;

        // reset settings: base 10, upper case
        add_val(64'd0, "0");
        add_val(64'h7FFF_FFFF_FFFF_FFFF, "9223372036854775807");
        add_val(64'h8000_0000_0000_0000, "-9223372036854775808");
        add_val(64'hFFFF_FFFF_FFFF_FFFF, "-1");
        add_val(64'd1, "1");
        add_cfg(srds_pkg::REG_RADIX, 6'd2);
        add_val(64'h8000_0000_0000_0000, "");
        add_val(64'hFFFF_FFFF_FFFF_FFFF, "1");
        add_val(64'h7FFF_FFFF_FFFF_FFFF, "");
        add_cfg(srds_pkg::REG_RADIX, 6'd36);
        add_val(64'h7FFF_FFFF_FFFF_FFFF, "");
        add_val(64'd35, "Z");
        add_cfg(srds_pkg::REG_UPPER, 6'h2A);
        add_val(64'd35, "z");
        add_val(-64'sd35, "z");
        add_cfg(srds_pkg::REG_RADIX, 6'd16);
        add_val(64'hDEAD_BEEF, "deadbeef");
        add_val(64'h8000_0000_0000_0000, "8000000000000000");
        // radix clamps
        add_cfg(srds_pkg::REG_RADIX, 6'd0);
        add_val(64'd5, "101");
        add_cfg(srds_pkg::REG_RADIX, 6'd1);
        add_val(64'd2, "10");
        add_cfg(srds_pkg::REG_RADIX, 6'h3F);
        add_val(64'd36, "10");
        add_cfg(srds_pkg::REG_RADIX, 6'd37);
        add_val(64'd71, "1z");
        add_cfg(srds_pkg::REG_RADIX, 6'd10);
        add_cfg(srds_pkg::REG_UPPER, 6'h15);
        add_val(-64'sd10, "-10");
        add_val(64'h0123_4567_89AB_CDEF, "");
        add_cfg(srds_pkg::REG_RADIX, 6'd8);
        add_val(-64'sd8, "10");

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                cfg_write(rows[i].idx, rows[i].data);
            end
            else
                send_value(rows[i].value, rows[i].text, 1'b0);
        end
        n_directed = n_values;

        rand_items = 0;
        phase      = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            wait_idle();
            if ($urandom_range(0, 1))
                cfg_write(srds_pkg::REG_UPPER, srds_pkg::RADIX_W'($urandom));
            case ($urandom_range(0, 5))
                0:       cfg_write(srds_pkg::REG_RADIX, 6'd2);
                1:       cfg_write(srds_pkg::REG_RADIX, 6'd36);
                2:       cfg_write(srds_pkg::REG_RADIX, 6'd10);
                3, 4:    cfg_write(srds_pkg::REG_RADIX,
                                   srds_pkg::RADIX_W'($urandom_range(2, 36)));
                default: cfg_write(srds_pkg::REG_RADIX,
                                   srds_pkg::RADIX_W'($urandom_range(0, 63)));
            endcase
            if ($urandom_range(0, 1))
                cfg_write(srds_pkg::REG_UPPER, srds_pkg::RADIX_W'($urandom));
            calm = ($urandom_range(0, 3) == 0);
            if (phase == 2)
                hold_req = 1'b1;
            len = $urandom_range(8, 20);
            if (len > RANDOM_ITEMS - rand_items)
                len = RANDOM_ITEMS - rand_items;
            repeat (len)
            begin
                send_value(rand_value(), "", calm);
                rand_items++;
            end
            phase++;
        end
        wait_idle();

        $display("Converted %0d values (%0d directed) into %0d characters, %0d register writes",
                 n_values, n_directed, n_chars, n_cfg);
        $display("Random phases: %0d, including one %0d-cycle output hold with input back-pressure",
                 phase, LONG_HOLD);
        if (n_errors == 0 && char_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
